FILE: src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, constants and helpers for the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned NUM_TIMERS  = 4;
  localparam int unsigned PERIOD_W    = 20;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned FLAGS_W     = 4;
  localparam logic [COUNT_W:0] COUNT_MAX = 33'd4294967295;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_POLL  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_STOP,
    OP_POLL,
    OP_VISIT,
    OP_INCR
  } dp_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VISIT,
    ST_INCR
  } state_e;

  typedef struct packed {
    dp_op_e                op;
    logic [IDX_W-1:0]      idx;
    logic                  cfg_we;
    logic [IDX_W-1:0]      cfg_idx;
    logic [PERIOD_W-1:0]   cfg_data;
  } dp_cmd_t;

  // true when a timer index addresses an existing timer
  function automatic logic idx_valid(input logic [IDX_W-1:0] idx);
    return {1'b0, idx} < (IDX_W+1)'(NUM_TIMERS);
  endfunction

  // headroom below the maximum count is less than twice the period
  function automatic logic room_short(input logic [COUNT_W-1:0] cnt,
                                      input logic [PERIOD_W-1:0] per);
    logic [COUNT_W:0] room;
    room = ({1'b0, cnt} >= COUNT_MAX) ? '0 : COUNT_MAX - {1'b0, cnt};
    return room < (COUNT_W+1)'({per, 1'b0});
  endfunction

endpackage

FILE: src/periodic_timer_table_core.sv
// ----------------------------------------------------------------------------
// periodic_timer_table_core
// Table of periodic timers sharing one tick count advanced by tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind_i and timer_index_i with start_i; the command
//   transfers on a rising edge with start_i high and busy_o low.
//   Each command gives exactly one result: done_o is high for one cycle with
//   pending_flags_o, enabled_mask_o and tick_value_o valid in that cycle.
//   The receiver cannot stall; results must be taken when shown.
//   Start, stop and poll: result in the cycle after the transfer, busy_o stays
//   low, so one of these may transfer every cycle.
//   Tick: the sequencer visits one timer per cycle, then updates the count;
//   busy_o is high through the visits and the count update, and the result
//   is registered from the count update. No other command transfers while
//   busy_o is high.
//   Configuration: cfg_valid_i / cfg_ready_o write period register
//   cfg_index_i with cfg_data_i on the handshake; cfg_ready_o is high only when
//   idle and no command is offered.
//   Reset: count, expiries, periods, enable and pending flags clear; no
//   result is pending.
// ----------------------------------------------------------------------------
module periodic_timer_table_core import ptt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          kind_i,
  input  logic [IDX_W-1:0]    timer_index_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  output logic                done_o,
  output logic [FLAGS_W-1:0]  pending_flags_o,
  output logic [FLAGS_W-1:0]  enabled_mask_o,
  output logic [COUNT_W-1:0]  tick_value_o
);

  dp_cmd_t cmd;

  ptt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .kind_i        (kind_i),
    .timer_index_i (timer_index_i),
    .busy_o        (busy_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_o         (cmd)
  );

  ptt_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .done_o          (done_o),
    .pending_flags_o (pending_flags_o),
    .enabled_mask_o  (enabled_mask_o),
    .tick_value_o    (tick_value_o)
  );

endmodule

FILE: src/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: accepts commands and walks the timer table one entry per cycle.
// ----------------------------------------------------------------------------
module ptt_ctrl import ptt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        kind_i,
  input  logic [IDX_W-1:0]  timer_index_i,
  output logic              busy_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  output dp_cmd_t           cmd_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  kind_e            kind;

  assign kind = kind_e'(kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ptr_d           = ptr_q;
    busy_o          = (state_q != ST_IDLE);
    cfg_ready_o     = (state_q == ST_IDLE) && !start_i;
    cmd_o.op        = OP_NONE;
    cmd_o.idx       = timer_index_i;
    cmd_o.cfg_we    = cfg_valid_i && cfg_ready_o;
    cmd_o.cfg_idx   = cfg_index_i;
    cmd_o.cfg_data  = cfg_data_i;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (kind)
            KIND_TICK: begin
              state_d = ST_VISIT;
              ptr_d   = '0;
            end
            KIND_START: cmd_o.op = OP_START;
            KIND_STOP:  cmd_o.op = OP_STOP;
            KIND_POLL:  cmd_o.op = OP_POLL;
            default:    cmd_o.op = OP_NONE;
          endcase
        end
      end
      ST_VISIT: begin
        cmd_o.op  = OP_VISIT;
        cmd_o.idx = ptr_q;
        if (ptr_q == IDX_W'(NUM_TIMERS - 1)) begin
          state_d = ST_INCR;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_INCR: begin
        cmd_o.op = OP_INCR;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: src/ptt_datapath.sv
// ----------------------------------------------------------------------------
// ptt_datapath
// Timer state (count, periods, expiries, flags) and the result register.
// ----------------------------------------------------------------------------
module ptt_datapath import ptt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output logic                done_o,
  output logic [FLAGS_W-1:0]  pending_flags_o,
  output logic [FLAGS_W-1:0]  enabled_mask_o,
  output logic [COUNT_W-1:0]  tick_value_o
);

  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [PERIOD_W-1:0] per_q [NUM_TIMERS];
  logic [PERIOD_W-1:0] per_d [NUM_TIMERS];
  logic [COUNT_W-1:0]  exp_q [NUM_TIMERS];
  logic [COUNT_W-1:0]  exp_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] en_q, en_d, pend_q, pend_d;
  logic                  vld_q, vld_d;
  logic [FLAGS_W-1:0]    rpend_q, rpend_d, ren_q, ren_d;
  logic [COUNT_W-1:0]    rcnt_q, rcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      en_q   <= '0;
      pend_q <= '0;
      vld_q  <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        per_q[i] <= '0;
        exp_q[i] <= '0;
      end
    end else begin
      cnt_q  <= cnt_d;
      en_q   <= en_d;
      pend_q <= pend_d;
      vld_q  <= vld_d;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        per_q[i] <= per_d[i];
        exp_q[i] <= exp_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rpend_q <= rpend_d;
    ren_q   <= ren_d;
    rcnt_q  <= rcnt_d;
  end

  always_comb begin
    logic [PERIOD_W-1:0] vper;
    logic [COUNT_W-1:0]  base;
    logic                shrt;
    cnt_d   = cnt_q;
    en_d    = en_q;
    pend_d  = pend_q;
    per_d   = per_q;
    exp_d   = exp_q;
    vld_d   = 1'b0;
    rpend_d = rpend_q;
    ren_d   = ren_q;
    rcnt_d  = rcnt_q;
    vper    = per_q[cmd_i.idx];
    base    = cnt_q;
    shrt    = 1'b0;

    unique case (cmd_i.op)
      OP_START, OP_STOP: begin
        if (idx_valid(cmd_i.idx)) begin
          en_d[cmd_i.idx] = (cmd_i.op == OP_START);
        end
        vld_d   = 1'b1;
        rpend_d = FLAGS_W'(pend_q);
        ren_d   = FLAGS_W'(en_d);
        rcnt_d  = cnt_q;
      end
      OP_POLL: begin
        pend_d  = '0;
        vld_d   = 1'b1;
        rpend_d = FLAGS_W'(pend_q);
        ren_d   = FLAGS_W'(en_q);
        rcnt_d  = cnt_q;
      end
      OP_VISIT: begin
        if (en_q[cmd_i.idx] && vper != '0 && exp_q[cmd_i.idx] <= cnt_q) begin
          pend_d[cmd_i.idx] = 1'b1;
          shrt = room_short(cnt_q, vper);
          if (shrt) begin
            base = '0;
            // count restart: every timer in use goes back to its period
            for (int j = 0; j < NUM_TIMERS; j++) begin
              if (per_q[j] != '0) exp_d[j] = COUNT_W'(per_q[j]);
            end
          end
          cnt_d = base;
          exp_d[cmd_i.idx] = COUNT_W'(vper) + base;
        end
      end
      OP_INCR: begin
        cnt_d   = ({1'b0, cnt_q} >= COUNT_MAX) ? '0 : cnt_q + 1'b1;
        vld_d   = 1'b1;
        rpend_d = FLAGS_W'(pend_q);
        ren_d   = FLAGS_W'(en_q);
        rcnt_d  = cnt_d;
      end
      default: ;
    endcase

    // register write: period, then arm with the same headroom rule as a tick
    if (cmd_i.cfg_we && idx_valid(cmd_i.cfg_idx)) begin
      per_d[cmd_i.cfg_idx] = cmd_i.cfg_data;
      if (cmd_i.cfg_data != '0) begin
        if (room_short(cnt_q, cmd_i.cfg_data)) begin
          cnt_d = '0;
          for (int j = 0; j < NUM_TIMERS; j++) begin
            if (per_d[j] != '0) exp_d[j] = COUNT_W'(per_d[j]);
          end
          exp_d[cmd_i.cfg_idx] = COUNT_W'(cmd_i.cfg_data);
        end else begin
          exp_d[cmd_i.cfg_idx] = COUNT_W'(cmd_i.cfg_data) + cnt_q;
        end
      end else begin
        exp_d[cmd_i.cfg_idx] = '0;
      end
    end
  end

  assign done_o          = vld_q;
  assign pending_flags_o = rpend_q;
  assign enabled_mask_o  = ren_q;
  assign tick_value_o    = rcnt_q;

endmodule

FILE: src/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of command timing for the periodic timer table.
// ----------------------------------------------------------------------------
module ptt_checker import ptt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic [1:0]          kind_i,
  input logic                cfg_ready_o,
  input logic                done_o
);

  // no result while the table walk is running
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");

  a_short_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i != KIND_TICK) |=> (done_o && !busy_o))
    else $error("start/stop/poll result missing");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_TICK) |=> busy_o)
    else $error("tick did not start the walk");

  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> ##(NUM_TIMERS + 1) done_o)
    else $error("tick result not on time");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> (!busy_o && !start_i))
    else $error("register write taken while busy");

endmodule

bind periodic_timer_table_core ptt_checker u_ptt_checker (.*);

FILE: verif/ptt_result_check.sv
// ----------------------------------------------------------------------------
// ptt_result_check
// Watches the command, configuration and result ports of the periodic timer
// table, keeps its own copy of the timer state, predicts the result of every
// command transfer and compares each result strobe field by field with the
// oldest prediction. Hands the failure count and the number of results still
// awaited to the testbench top.
// ----------------------------------------------------------------------------
module ptt_result_check import ptt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  logic [1:0]          kind_i,
  input  logic [IDX_W-1:0]    timer_index_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  input  logic                done_o,
  input  logic [FLAGS_W-1:0]  pending_flags_o,
  input  logic [FLAGS_W-1:0]  enabled_mask_o,
  input  logic [COUNT_W-1:0]  tick_value_o,
  output int unsigned         mismatch_count_o,
  output int unsigned         awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [FLAGS_W-1:0] mask;
    logic [COUNT_W-1:0] count;
  } timer_report_t;

  logic [COUNT_W-1:0]    count_q;
  logic [COUNT_W-1:0]    expiry_q [NUM_TIMERS];
  logic [PERIOD_W-1:0]   period_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] enable_q;
  logic [NUM_TIMERS-1:0] pending_q;
  timer_report_t         report_q [$];
  timer_report_t         want;
  int unsigned           mismatches = 0;

  // rearm one timer; the count restarts when too close to its maximum
  function automatic void reload_timer(input int unsigned t);
    logic [COUNT_W:0] room;
    room = ({1'b0, count_q} >= COUNT_MAX) ? '0 : COUNT_MAX - {1'b0, count_q};
    if (room < (COUNT_W+1)'({period_q[t], 1'b0})) begin
      count_q = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (period_q[i] != '0) expiry_q[i] = COUNT_W'(period_q[i]);
      end
    end
    expiry_q[t] = COUNT_W'(period_q[t]) + count_q;
  endfunction

  function automatic void load_period(input logic [IDX_W-1:0] idx,
                                      input logic [PERIOD_W-1:0] per);
    if (idx < NUM_TIMERS) begin
      period_q[idx] = per;
      if (per != '0) reload_timer(idx);
      else expiry_q[idx] = '0;
    end
  endfunction

  function automatic timer_report_t apply_command(input kind_e kind,
                                                  input logic [IDX_W-1:0] idx);
    timer_report_t rep;
    case (kind)
      KIND_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (enable_q[i] && period_q[i] != '0 && expiry_q[i] <= count_q) begin
            pending_q[i] = 1'b1;
            reload_timer(i);
          end
        end
        count_q = ({1'b0, count_q} >= COUNT_MAX) ? '0 : count_q + 1'b1;
        rep.flags = pending_q;
      end
      KIND_START, KIND_STOP: begin
        if (idx < NUM_TIMERS) enable_q[idx] = (kind == KIND_START);
        rep.flags = pending_q;
      end
      default: begin
        // poll shows the flags as they were, then clears them
        rep.flags = pending_q;
        pending_q = '0;
      end
    endcase
    rep.mask  = enable_q;
    rep.count = count_q;
    return rep;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   = '0;
      enable_q  = '0;
      pending_q = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        expiry_q[i] = '0;
        period_q[i] = '0;
      end
      report_q.delete();
    end else begin
      // results belong to earlier transfers, so compare before predicting
      if (done_o) begin
        if (report_q.size() == 0) begin
          note_mismatch($sformatf("result with no command waiting: flags %h mask %h count %0d",
                                  pending_flags_o, enabled_mask_o, tick_value_o));
        end else begin
          want = report_q.pop_front();
          if (want.flags !== pending_flags_o || want.mask !== enabled_mask_o ||
              want.count !== tick_value_o) begin
            note_mismatch($sformatf({"expected flags %h mask %h count %0d, ",
                                     "got flags %h mask %h count %0d"},
                                    want.flags, want.mask, want.count,
                                    pending_flags_o, enabled_mask_o, tick_value_o));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) load_period(cfg_index_i, cfg_data_i);
      if (start_i && !busy_o) report_q.push_back(apply_command(kind_e'(kind_i), timer_index_i));
    end
    mismatch_count_o <= mismatches;
    awaited_count_o  <= report_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the periodic timer table: a short directed sequence, then
// random phases of ticks, starts, stops and polls under changing timer periods
// and sender gaps. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int unsigned         RUN_LIMIT      = 500000;
  localparam int unsigned         PHASES         = 8;
  localparam int unsigned         ITEMS_PER_PHASE = 178;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX     = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_UNUSED  = '0;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          kind_i;
  logic [IDX_W-1:0]    timer_index_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [IDX_W-1:0]    cfg_index_i;
  logic [PERIOD_W-1:0] cfg_data_i;
  logic                done_o;
  logic [FLAGS_W-1:0]  pending_flags_o;
  logic [FLAGS_W-1:0]  enabled_mask_o;
  logic [COUNT_W-1:0]  tick_value_o;

  int unsigned         mismatch_count;
  int unsigned         awaited_count;
  int unsigned         idle_pct = 0;
  int unsigned         cycle_count = 0;
  logic [PERIOD_W-1:0] period_plan [NUM_TIMERS];

  periodic_timer_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .timer_index_i   (timer_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .pending_flags_o (pending_flags_o),
    .enabled_mask_o  (enabled_mask_o),
    .tick_value_o    (tick_value_o)
  );

  ptt_result_check result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .timer_index_i    (timer_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .pending_flags_o  (pending_flags_o),
    .enabled_mask_o   (enabled_mask_o),
    .tick_value_o     (tick_value_o),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // random sender gaps, then hold the command until it transfers
  task automatic issue_command(input kind_e kind, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    kind_i        <= kind;
    timer_index_i <= idx;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (awaited_count != 0);
    repeat (NUM_TIMERS + 2) @(posedge clk_i);
  endtask

  task automatic program_periods();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= IDX_W'(i);
      cfg_data_i  <= period_plan[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    kind_e       kind_pick;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    kind_i        = KIND_TICK;
    timer_index_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all periods zero: an enabled timer without a period must stay quiet
    issue_command(KIND_TICK, '0);
    issue_command(KIND_START, IDX_W'(3));
    issue_command(KIND_TICK, '0);
    issue_command(KIND_STOP, IDX_W'(3));
    issue_command(KIND_POLL, '0);
    wait_for_results();

    period_plan[0] = 20'd1;
    period_plan[1] = 20'd2;
    period_plan[2] = PERIOD_MAX;
    period_plan[3] = PERIOD_UNUSED;
    program_periods();
    for (int t = 0; t < NUM_TIMERS; t++) issue_command(KIND_START, IDX_W'(t));
    repeat (4) issue_command(KIND_TICK, '0);
    issue_command(KIND_POLL, '0);
    issue_command(KIND_POLL, '0);
    issue_command(KIND_STOP, '0);
    repeat (3) issue_command(KIND_TICK, '0);
    // expiry left behind while stopped fires on the first tick after restart
    issue_command(KIND_START, '0);
    issue_command(KIND_TICK, '0);
    issue_command(KIND_POLL, '0);
    issue_command(KIND_STOP, IDX_W'(1));
    issue_command(KIND_STOP, IDX_W'(2));

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      for (int i = 0; i < NUM_TIMERS; i++) begin
        case ($urandom_range(9))
          0: period_plan[i] = PERIOD_UNUSED;
          1: period_plan[i] = PERIOD_MAX;
          2: period_plan[i] = PERIOD_W'($urandom_range(PERIOD_MAX));
          default: period_plan[i] = PERIOD_W'($urandom_range(16, 1));
        endcase
      end
      if (phase == 0) begin
        period_plan[0] = PERIOD_UNUSED;
        period_plan[3] = PERIOD_MAX;
      end
      program_periods();
      case (phase % 4)
        1: idle_pct = 74;
        3: idle_pct = 31;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) kind_pick = KIND_TICK;
        else if (pick < 70) kind_pick = KIND_START;
        else if (pick < 80) kind_pick = KIND_STOP;
        else kind_pick = KIND_POLL;
        issue_command(kind_pick, IDX_W'($urandom_range(NUM_TIMERS - 1)));
        if ($urandom_range(63) == 0) wait_for_results();
      end
    end

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ptt_pkg.sv
src/ptt_ctrl.sv
src/ptt_datapath.sv
src/periodic_timer_table_core.sv
src/ptt_checker.sv
verif/ptt_result_check.sv
verif/tb_top.sv
